/* rtl/prle_pkg.sv */
// Shared constants and types for the palette run-length encoder.
package prle_pkg;

    localparam int PAL_DEPTH = 64;
    localparam int IDX_W     = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
    localparam int PCNT_W    = $clog2(PAL_DEPTH + 1);
    localparam int MAX_LINE  = 4096;
    localparam int RUN_W     = $clog2(MAX_LINE + 1);
    localparam int LEN_W     = 13;
    localparam int CIDX_W    = 6;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    // classified pixel handed from the palette front to the run back end
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        rgb_t             color;
        logic [7:0]       alpha;
        logic             first;
        logic             last;
        logic             full;
    } item_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CIDX_W-1:0] cidx;
        rgb_t              color;
        logic              valid;
        logic              eol;
        logic              full;
    } result_t;

endpackage

/* rtl/prle_front.sv */
// Palette front: content-addressed color lookup and index assignment.
module prle_front (
    input  logic            clk,
    input  logic            rst_n,
    input  prle_pkg::rgb_t  pix_color,
    input  logic [7:0]      pix_alpha,
    input  logic            line_first,
    input  logic            line_last,
    input  logic            image_first,
    input  logic            take,
    output prle_pkg::item_t item
);
    import prle_pkg::*;

    rgb_t              pal_reg [PAL_DEPTH];
    logic [PCNT_W-1:0] pcnt_reg, pcnt_next;
    logic              ovf_reg, ovf_next;
    logic [PCNT_W-1:0] eff_cnt;
    logic              eff_ovf;
    logic [PAL_DEPTH-1:0] match;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic              do_insert;

    always_comb
    begin
        eff_cnt = image_first ? '0 : pcnt_reg;
        eff_ovf = image_first ? 1'b0 : ovf_reg;
        hit_idx = '0;
        for (int i = 0; i < PAL_DEPTH; i++)
        begin
            match[i] = (PCNT_W'(i) < eff_cnt) && (pal_reg[i] == pix_color);
            if (match[i])
                hit_idx = hit_idx | IDX_W'(i);
        end
        hit = |match;

        do_insert  = 1'b0;
        pcnt_next  = eff_cnt;
        ovf_next   = eff_ovf;
        item.color = pix_color;
        if (hit)
        begin
            item.idx = hit_idx;
        end
        else if (eff_cnt < PCNT_W'(PAL_DEPTH))
        begin
            item.idx  = eff_cnt[IDX_W-1:0];
            do_insert = 1'b1;
            pcnt_next = eff_cnt + PCNT_W'(1);
        end
        else
        begin
            // palette full: map to the last entry
            item.idx   = IDX_W'(PAL_DEPTH - 1);
            item.color = pal_reg[PAL_DEPTH-1];
            ovf_next   = 1'b1;
        end
        item.alpha = pix_alpha;
        item.first = line_first;
        item.last  = line_last;
        item.full  = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (take)
        begin
            pcnt_reg <= pcnt_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && do_insert)
            pal_reg[eff_cnt[IDX_W-1:0]] <= pix_color;
    end

endmodule

/* rtl/prle_queue.sv */
// Short queue of classified pixels between the front and the back end.
module prle_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  prle_pkg::item_t push_item,
    output logic            not_full,
    input  logic            pop,
    output logic            not_empty,
    output prle_pkg::item_t head
);
    import prle_pkg::*;

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign not_full  = (cnt_reg != QCNT_W'(QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + QPTR_W'(1);
            if (pop)
                rd_reg <= rd_reg + QPTR_W'(1);
            cnt_reg <= cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

endmodule

/* rtl/prle_back.sv */
// Run back end: tracks the open run, emits results through a two-slot buffer.
module prle_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  prle_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              res_valid,
    input  logic              res_ready,
    output prle_pkg::result_t res
);
    import prle_pkg::*;

    logic [IDX_W-1:0] run_idx_reg, run_idx_next;
    rgb_t             run_color_reg, run_color_next;
    logic [7:0]       run_alpha_reg, run_alpha_next;
    logic [RUN_W-1:0] run_cnt_reg, run_cnt_next;
    result_t          slot_reg [2];
    result_t          slot_next [2];
    logic [1:0]       ocnt_reg, ocnt_next, ocnt_after;
    logic             emit0, emit1, restart, opop;
    logic [1:0]       npush;
    result_t          r0, r1, r_one;
    logic [RUN_W-1:0] new_cnt;
    logic [31:0]      len32, idx32;

    always_comb
    begin
        emit0   = 1'b0;
        restart = 1'b1;
        if (!q_item.first && run_cnt_reg != '0)
        begin
            restart = (q_item.idx != run_idx_reg) || (q_item.alpha != run_alpha_reg);
            emit0   = restart && (run_alpha_reg != 8'd0);
        end
        emit1 = q_item.last;
        npush = {1'b0, emit0} + {1'b0, emit1};

        // result for a run change, from the run as it stands
        len32      = 32'(run_cnt_reg);
        idx32      = 32'(run_idx_reg);
        r0.len     = len32[LEN_W-1:0];
        r0.cidx    = idx32[CIDX_W-1:0];
        r0.color   = run_color_reg;
        r0.valid   = 1'b1;
        r0.eol     = 1'b0;
        r0.full    = q_item.full;

        run_idx_next   = run_idx_reg;
        run_color_next = run_color_reg;
        run_alpha_next = run_alpha_reg;
        if (restart)
        begin
            run_idx_next   = q_item.idx;
            run_color_next = q_item.color;
            run_alpha_next = q_item.alpha;
            new_cnt        = RUN_W'(1);
        end
        else if (run_cnt_reg < RUN_W'(MAX_LINE))
            new_cnt = run_cnt_reg + RUN_W'(1);
        else
            new_cnt = run_cnt_reg;

        // closing result at line end, from the updated run
        len32 = 32'(new_cnt);
        idx32 = 32'(run_idx_next);
        if (run_alpha_next != 8'd0)
        begin
            r1.len   = len32[LEN_W-1:0];
            r1.cidx  = idx32[CIDX_W-1:0];
            r1.color = run_color_next;
            r1.valid = 1'b1;
        end
        else
        begin
            r1.len   = '0;
            r1.cidx  = '0;
            r1.color = '0;
            r1.valid = 1'b0;
        end
        r1.eol  = 1'b1;
        r1.full = q_item.full;

        run_cnt_next = q_item.last ? '0 : new_cnt;

        opop       = (ocnt_reg != 2'd0) && res_ready;
        ocnt_after = ocnt_reg - {1'b0, opop};

        // take the item only when the buffer has room for all its results
        case (npush)
            2'd0:    q_pop = q_valid;
            2'd1:    q_pop = q_valid && (ocnt_after != 2'd2);
            default: q_pop = q_valid && (ocnt_after == 2'd0);
        endcase

        slot_next[0] = opop ? slot_reg[1] : slot_reg[0];
        slot_next[1] = slot_reg[1];
        r_one = emit0 ? r0 : r1;
        ocnt_next = ocnt_after;
        if (q_pop)
        begin
            ocnt_next = ocnt_after + npush;
            if (npush == 2'd2)
            begin
                slot_next[0] = r0;
                slot_next[1] = r1;
            end
            else if (npush == 2'd1)
            begin
                if (ocnt_after == 2'd0)
                    slot_next[0] = r_one;
                else
                    slot_next[1] = r_one;
            end
        end
    end

    assign res_valid = (ocnt_reg != 2'd0);
    assign res       = slot_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_idx_reg   <= '0;
            run_color_reg <= '0;
            run_alpha_reg <= '0;
            run_cnt_reg   <= '0;
            ocnt_reg      <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                run_idx_reg   <= run_idx_next;
                run_color_reg <= run_color_next;
                run_alpha_reg <= run_alpha_next;
                run_cnt_reg   <= run_cnt_next;
            end
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg <= 2'd2)
        else $error("result buffer count out of range");

    a_run_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_cnt_reg <= RUN_W'(MAX_LINE))
        else $error("run count above line limit");

    a_line_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_item.last) |=> (run_cnt_reg == '0))
        else $error("line still open after line end");

    a_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.valid) |-> (res.len == '0 && res.eol))
        else $error("closing result carries a run");

endmodule

/* rtl/palette_run_length_encoder.sv */
// A pixel is classified on acceptance, held in the queue, and its results are
// registered in the output buffer. Throughput: one pixel per clock unless the queue or
// buffer is full; a pixel closing a run at line end yields two results for the single result port.
// The palette match is a parallel compare over all entries, updated per pixel.
// Reset (rst_n low, asynchronous) empties the queue and the output buffer, clears
// run and palette counts; palette contents stay undefined, masked by the fill count.
module palette_run_length_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red, green, blue, alpha
    input  logic        s_axis_tlast,   // line_last
    input  logic [1:0]  s_axis_tuser,   // line_first, image_first
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // run_length, pal_index, run_red, run_green, run_blue
    output logic        m_axis_tlast,   // end_of_line
    output logic [1:0]  m_axis_tuser    // run_valid, palette_full
);
    import prle_pkg::*;

    rgb_t    pix_color;
    item_t   front_item, q_head;
    logic    q_not_full, q_not_empty, q_pop, take;
    result_t res;

    assign pix_color.red   = s_axis_tdata[7:0];
    assign pix_color.green = s_axis_tdata[15:8];
    assign pix_color.blue  = s_axis_tdata[23:16];
    assign s_axis_tready   = q_not_full;
    assign take            = s_axis_tvalid && q_not_full;

    prle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_color   (pix_color),
        .pix_alpha   (s_axis_tdata[31:24]),
        .line_first  (s_axis_tuser[0]),
        .line_last   (s_axis_tlast),
        .image_first (s_axis_tuser[1]),
        .take        (take),
        .item        (front_item)
    );

    prle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_item (front_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    prle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_item    (q_head),
        .q_pop     (q_pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {5'b0, res.color.blue, res.color.green, res.color.red,
                           res.cidx, res.len};
    assign m_axis_tlast = res.eol;
    assign m_axis_tuser = {res.full, res.valid};

endmodule
